### design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfd assertion failed");

`endif

### design/scfd_pkg.sv
// Package with constants and types of the serial CAN frame deframer.
package scfd_pkg;

    localparam int MAX_PAYLOAD   = 8;
    localparam int HDR_BYTES     = 10;
    localparam int WIN_DEPTH     = HDR_BYTES + MAX_PAYLOAD;
    localparam int IDX_W         = $clog2(WIN_DEPTH);
    localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
    localparam int BYTE_W        = 8;
    localparam int ID_W          = 16;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_W     = BYTE_W * MAX_PAYLOAD;

    localparam int MARK_POS      = 5;
    localparam int ID_HI_POS     = 6;
    localparam int ID_LO_POS     = 7;
    localparam int LEN_POS       = 8;
    localparam int FIRST_PAY_POS = 9;
    localparam int MARK_FILL     = MARK_POS + 1;
    localparam int LEN_FILL      = LEN_POS + 1;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hBB;
    localparam logic [BYTE_W-1:0] MARK_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hEE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DROP
    } t_state;

    typedef enum logic [1:0] {
        VD_BAD,
        VD_PARTIAL,
        VD_COMPLETE
    } t_verdict;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

### design/scfd_cell.sv
// One byte cell of the window chain; it loads a new byte or takes its right neighbor's byte.
module scfd_cell
    import scfd_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_load_data,
    input  logic [BYTE_W-1:0] i_next_data,
    output logic [BYTE_W-1:0] o_data
);

    logic [BYTE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data <= i_load_data;
        end else if (i_ctrl.shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

### design/serial_can_frame_deframer_top.sv
// Top level of the serial CAN frame deframer: byte cell chain, scan control and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | i_valid / o_ready   | i_rx_byte
//  output   | o_valid / i_ready   | o_frame_id, o_payload_len, o_payload
//
// Each byte enters in ST_IDLE and is followed by scanning in ST_SCAN before the next byte is taken.
// The window moves by one cell per cycle while it shifts: on a bad front, in ST_DROP or when a
// byte enters a full window; a byte's handling is entry, at most 18 one-cell shifts, the emit
// and the closing scan.
// Synchronous active-low reset empties the window; no clearing pass is needed.
// A held result stalls scanning only while another complete frame waits at the front.
module serial_can_frame_deframer_top
    import scfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_W-1:0]      o_frame_id,
    output logic [LEN_W-1:0]     o_payload_len,
    output logic [PAYLOAD_W-1:0] o_payload
);

    t_state                r_state;
    t_state                n_state;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic [FILL_W-1:0]     r_drop_cnt;
    logic [FILL_W-1:0]     n_drop_cnt;
    logic                  r_emitted;
    logic                  n_emitted;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [ID_W-1:0]       r_out_id;
    logic [LEN_W-1:0]      r_out_len;
    logic [PAYLOAD_W-1:0]  r_out_payload;

    logic [BYTE_W-1:0]     w_cell_data [WIN_DEPTH];
    t_cell_ctrl            w_ctrl [WIN_DEPTH];

    logic                  w_accept;
    logic                  w_full;
    logic                  w_out_free;
    logic                  w_shift;
    logic                  w_emit;
    t_verdict              w_verdict;
    logic [BYTE_W-1:0]     w_len_byte;
    logic                  w_len_bad;
    logic [LEN_W-1:0]      w_len;
    logic [IDX_W-1:0]      w_end_idx;
    logic [FILL_W-1:0]     w_frame_bytes;
    logic [PAYLOAD_W-1:0]  w_payload;

    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_fill == FILL_W'(WIN_DEPTH));
    assign w_out_free = !r_out_valid || i_ready;

    // Byte cell chain; entry 0 is the oldest byte.
    genvar g;
    generate
        for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
            logic [BYTE_W-1:0] w_next;
            if (g == WIN_DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_cell_data[g+1];
            end
            assign w_ctrl[g].shift = w_shift;
            assign w_ctrl[g].load  = w_accept &&
                (w_full ? (g == WIN_DEPTH - 1) : (r_fill == FILL_W'(g)));
            scfd_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[g]),
                .i_load_data (i_rx_byte),
                .i_next_data (w_next),
                .o_data      (w_cell_data[g])
            );
        end
    endgenerate

    // Judgment of the frame at the front of the window.
    assign w_len_byte    = w_cell_data[LEN_POS];
    assign w_len_bad     = (w_len_byte > BYTE_W'(MAX_PAYLOAD));
    assign w_len         = w_len_byte[LEN_W-1:0];
    assign w_end_idx     = w_len_bad ? '0 : (IDX_W'(FIRST_PAY_POS) + IDX_W'(w_len));
    assign w_frame_bytes = FILL_W'(HDR_BYTES) + FILL_W'(w_len);

    always_comb begin
        if (w_cell_data[0] != START_BYTE) begin
            w_verdict = VD_BAD;
        end else if (r_fill < FILL_W'(MARK_FILL)) begin
            w_verdict = VD_PARTIAL;
        end else if (w_cell_data[MARK_POS] != MARK_BYTE) begin
            w_verdict = VD_BAD;
        end else if (r_fill < FILL_W'(LEN_FILL)) begin
            w_verdict = VD_PARTIAL;
        end else if (w_len_bad) begin
            w_verdict = VD_BAD;
        end else if (r_fill < w_frame_bytes) begin
            w_verdict = VD_PARTIAL;
        end else if (w_cell_data[w_end_idx] != END_BYTE) begin
            w_verdict = VD_BAD;
        end else begin
            w_verdict = VD_COMPLETE;
        end
    end

    always_comb begin
        w_payload = '0;
        for (int k = 0; k < MAX_PAYLOAD; k++) begin
            if (LEN_W'(k) < w_len) begin
                w_payload[PAYLOAD_W-1-BYTE_W*k -: BYTE_W] = w_cell_data[FIRST_PAY_POS + k];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_fill == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    case (w_verdict)
                        VD_BAD:      n_state = ST_SCAN;
                        VD_PARTIAL:  n_state = ST_IDLE;
                        VD_COMPLETE: begin
                            if (r_emitted) begin
                                n_state = ST_IDLE;
                            end else if (w_out_free) begin
                                n_state = ST_DROP;
                            end
                        end
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DROP: begin
                if (r_drop_cnt == FILL_W'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_ready = 1'b0;
        w_shift = 1'b0;
        w_emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                w_shift = w_accept && w_full;
            end
            ST_SCAN: begin
                if (r_fill != '0) begin
                    w_shift = (w_verdict == VD_BAD);
                    w_emit  = (w_verdict == VD_COMPLETE) && !r_emitted && w_out_free;
                end
            end
            ST_DROP: begin
                w_shift = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Fill count, drop count and result register next values.
    always_comb begin
        n_fill      = r_fill;
        n_drop_cnt  = r_drop_cnt;
        n_emitted   = r_emitted;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_emitted = 1'b0;
            if (!w_full) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end else if (w_shift) begin
            n_fill = r_fill - FILL_W'(1);
        end
        if (r_state == ST_DROP) begin
            n_drop_cnt = r_drop_cnt - FILL_W'(1);
        end
        if (w_emit) begin
            n_emitted   = 1'b1;
            n_drop_cnt  = w_frame_bytes;
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_drop_cnt  <= '0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop_cnt  <= n_drop_cnt;
            r_emitted   <= n_emitted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_id      <= {w_cell_data[ID_HI_POS], w_cell_data[ID_LO_POS]};
            r_out_len     <= w_len;
            r_out_payload <= w_payload;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_id    = r_out_id;
    assign o_payload_len = r_out_len;
    assign o_payload     = r_out_payload;

endmodule

### design/scfd_checker.sv
// Port-level checker for the serial CAN frame deframer, bound to its top level.
`include "assert_macros.svh"

module scfd_checker
    import scfd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [ID_W-1:0]      o_frame_id,
    input logic [LEN_W-1:0]     o_payload_len,
    input logic [PAYLOAD_W-1:0] o_payload
);

    logic [PAYLOAD_W-1:0]            w_unused_mask;
    logic [ID_W+LEN_W+PAYLOAD_W-1:0] w_out_bundle;

    // Bytes past the payload length must read as zero.
    assign w_unused_mask = {PAYLOAD_W{1'b1}} >> {o_payload_len, 3'b000};
    assign w_out_bundle  = {o_frame_id, o_payload_len, o_payload};

    `SCFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(w_out_bundle))
    `SCFD_ASSERT_NOW(a_len_range, i_clk, i_rst_n, o_valid, o_payload_len <= LEN_W'(MAX_PAYLOAD))
    `SCFD_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_valid, (o_payload & w_unused_mask) == '0)
    `SCFD_ASSERT_NEXT(a_scan_after_byte, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind serial_can_frame_deframer_top scfd_checker u_scfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_frame_id    (o_frame_id),
    .o_payload_len (o_payload_len),
    .o_payload     (o_payload)
);
